// ----- rtl/core/psca_pkg.sv -----
package psca_pkg;

  // Heap geometry
  localparam int unsigned HEAP_BYTES    = 1048576;
  localparam int unsigned SIZE_CLASSES  = 20;
  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned GRANULE_BYTES = 8;

  localparam int unsigned HDR_DEPTH = HEAP_BYTES / GRANULE_BYTES;
  localparam int unsigned IDX_W     = $clog2(HDR_DEPTH);
  localparam int unsigned GRAN_SH   = $clog2(GRANULE_BYTES);
  localparam int unsigned ADDR_SPAN = 1048576;
  localparam int unsigned BUMP_MAX  = (HEAP_BYTES < ADDR_SPAN) ? HEAP_BYTES : ADDR_SPAN;
  localparam int unsigned MAX_REQ   = 1 << (SIZE_CLASSES - 1);

  // Field widths
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned REQ_W  = 24;
  localparam int unsigned ADDR_W = 20;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned COPY_W = 20;
  localparam int unsigned LIM_W  = 21;
  localparam int unsigned BP_W   = 21;
  localparam int unsigned CLS_W  = 5;
  localparam int unsigned NEXT_W = 18;
  localparam int unsigned TDATA_W = 48;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_REALLOC = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_MEM    = 3'd2,
    ST_BAD_PTR   = 3'd3,
    ST_CORRUPT   = 3'd4
  } status_e;

  // Per-granule header word, 26 bits
  typedef struct packed {
    logic              start;
    logic              alloc;
    logic [CLS_W-1:0]  cls;
    logic              next_vld;
    logic [NEXT_W-1:0] next;
  } hdr_t;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_HDR    = 7'b0001000,
    S_POP    = 7'b0010000,
    S_REL    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  // Smallest class p >= 1 with n <= 2^p (MSB of n-1, plus one)
  function automatic logic [CLS_W-1:0] size_class(input logic [REQ_W-1:0] n);
    logic [REQ_W-1:0] nm1;
    logic [CLS_W-1:0] msb;
    nm1 = n - REQ_W'(1);
    msb = CLS_W'(1);
    for (int i = 1; i < REQ_W; i++) begin
      if (nm1[i]) msb = CLS_W'(i + 1);
    end
    if (n <= REQ_W'(2)) msb = CLS_W'(1);
    return msb;
  endfunction

  // Header plus 2^cls data bytes, rounded up to a granule
  function automatic logic [BP_W-1:0] bump_size(input logic [CLS_W-1:0] cls);
    logic [BP_W-1:0] s;
    s = BP_W'(HEADER_BYTES) + (BP_W'(1) << cls) + BP_W'(GRANULE_BYTES - 1);
    return s & ~BP_W'(GRANULE_BYTES - 1);
  endfunction

endpackage

// ----- rtl/core/pow2_size_class_allocator.sv -----
// Power-of-two size-class heap allocator.
// Slave stream carries one request per transaction: action (allocate, free,
// reallocate), requested byte count and the data address of an existing block.
// Master stream returns one transaction per request: granted data address,
// status and the number of bytes the requester must copy after a moving
// reallocate. cfg_we_i/cfg_wdata_i set the heap limit; write it only while idle.
// Block headers live in a single-port synchronous RAM, one word per granule;
// free-stack heads per class sit in flops.
// After reset the header RAM is swept to zero, one entry per cycle:
// all 131072 entries, during which s_axis_tready stays low.
// Bump allocate, null free, no-op and errors found before a header read go from
// S_DECODE to S_DONE; pop, free and in-place reallocate pass through S_POP
// or S_HDR; moving reallocate passes S_HDR, S_POP if it pops, and S_REL.
// One request is in flight at a time; the next is taken the cycle after the
// result enters the output register.
// Each step makes at most one access of the header RAM port, whose read data are registered.
// A stalled master side holds the result in the output register; one more
// request is taken and worked through, then the block waits in its final
// state with s_axis_tready low until the output register is free.
module pow2_size_class_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // action [1:0], request_bytes [25:2], block_addr [45:26]
  input  logic [psca_pkg::TDATA_W-1:0]  s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // result_addr [19:0], status [22:20], copy_bytes [42:23]
  output logic [psca_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [psca_pkg::LIM_W-1:0]    cfg_wdata_i
);

  localparam int unsigned IDX_W   = psca_pkg::IDX_W;
  localparam int unsigned ADDR_W  = psca_pkg::ADDR_W;
  localparam int unsigned REQ_W   = psca_pkg::REQ_W;
  localparam int unsigned BP_W    = psca_pkg::BP_W;
  localparam int unsigned LIM_W   = psca_pkg::LIM_W;
  localparam int unsigned CLS_W   = psca_pkg::CLS_W;
  localparam int unsigned NEXT_W  = psca_pkg::NEXT_W;
  localparam int unsigned COPY_W  = psca_pkg::COPY_W;
  localparam int unsigned GRAN_SH = psca_pkg::GRAN_SH;
  localparam int unsigned NCLS    = psca_pkg::SIZE_CLASSES;

  // ---------------------------------------------------------------- state
  psca_pkg::state_e  state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [BP_W-1:0]   bp_q, bp_d;
  logic [LIM_W-1:0]  limit_q;
  logic              move_q, move_d;
  psca_pkg::hdr_t    hold_q, hold_d;

  logic [NEXT_W-1:0] head_q     [NCLS];
  logic              head_vld_q [NCLS];

  // latched request
  psca_pkg::action_e act_q;
  logic [REQ_W-1:0]  n_q;
  logic [ADDR_W-1:0] ptr_q;

  // pending result and output register
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  psca_pkg::status_e res_st_q, res_st_d;
  logic [COPY_W-1:0] res_copy_q, res_copy_d;
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  psca_pkg::status_e out_st_q;
  logic [COPY_W-1:0] out_copy_q;

  // header RAM port
  psca_pkg::hdr_t    hdr_mem [psca_pkg::HDR_DEPTH];
  psca_pkg::hdr_t    mem_rdata_q;
  psca_pkg::hdr_t    mem_wdata;
  logic [IDX_W-1:0]  mem_addr;
  logic              mem_en, mem_we;

  // head table port
  logic [CLS_W-1:0]  cls_sel;
  logic [NEXT_W-1:0] head_sel;
  logic              head_vld_sel;
  logic              head_we;
  logic [NEXT_W-1:0] head_wnext;
  logic              head_wvld;

  // datapath
  logic [CLS_W-1:0]  p_cls;
  logic              too_large;
  logic [BP_W-1:0]   bsize;
  logic [LIM_W-1:0]  lim;
  logic              no_mem;
  logic [ADDR_W-1:0] hdr_off;
  logic [ADDR_W-GRAN_SH-1:0] ptr_gran;
  logic              ptr_zero, ptr_ok;
  logic [IDX_W-1:0]  ptr_idx;
  logic              head_in_range;
  logic              osize_ge;
  logic              start_alloc;
  logic              out_free;
  psca_pkg::hdr_t    rel_src, rel_hdr, pop_hdr, bump_hdr;
  logic              rel_push;

  assign s_axis_tready = (state_q == psca_pkg::S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_copy_q, out_st_q, out_addr_q};

  // ---------------------------------------------------------------- datapath
  assign p_cls     = psca_pkg::size_class(n_q);
  assign too_large = 32'(n_q) > psca_pkg::MAX_REQ;
  assign bsize     = psca_pkg::bump_size(p_cls);
  assign lim       = (32'(limit_q) > psca_pkg::BUMP_MAX) ? LIM_W'(psca_pkg::BUMP_MAX) : limit_q;
  assign no_mem    = ({1'b0, bp_q} + {1'b0, bsize}) > {1'b0, lim};

  assign hdr_off   = ptr_q - ADDR_W'(psca_pkg::HEADER_BYTES);
  assign ptr_gran  = hdr_off[ADDR_W-1:GRAN_SH];
  assign ptr_zero  = (ptr_q == '0);
  assign ptr_ok    = (32'(ptr_q) >= psca_pkg::HEADER_BYTES)
                  && (hdr_off[GRAN_SH-1:0] == '0)
                  && (32'(ptr_gran) < psca_pkg::HDR_DEPTH);
  assign ptr_idx   = IDX_W'(ptr_gran);

  assign head_sel      = (32'(cls_sel) < NCLS) ? head_q[cls_sel] : '0;
  assign head_vld_sel  = (32'(cls_sel) < NCLS) ? head_vld_q[cls_sel] : 1'b0;
  assign head_in_range = 32'(head_sel) < psca_pkg::HDR_DEPTH;

  // old class covers request when 2^cls >= n
  assign osize_ge = (33'(1) << mem_rdata_q.cls) >= 33'(n_q);

  // release: old header from RAM (free) or held copy (moving reallocate)
  assign rel_src  = (state_q == psca_pkg::S_HDR) ? mem_rdata_q : hold_q;
  assign rel_push = 32'(rel_src.cls) < NCLS;
  always_comb begin
    rel_hdr          = rel_src;
    rel_hdr.alloc    = 1'b0;
    rel_hdr.next_vld = 1'b0;
    rel_hdr.next     = '0;
    if (rel_push && head_vld_sel) begin
      rel_hdr.next_vld = 1'b1;
      rel_hdr.next     = head_sel;
    end
  end

  always_comb begin
    pop_hdr          = mem_rdata_q;
    pop_hdr.alloc    = 1'b1;
    pop_hdr.next_vld = 1'b0;
    pop_hdr.next     = '0;
  end

  always_comb begin
    bump_hdr       = '0;
    bump_hdr.start = 1'b1;
    bump_hdr.alloc = 1'b1;
    bump_hdr.cls   = p_cls;
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    bp_d        = bp_q;
    move_d      = move_q;
    hold_d      = hold_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    res_copy_d  = res_copy_q;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = ptr_idx;
    mem_wdata   = rel_hdr;
    cls_sel     = p_cls;
    head_we     = 1'b0;
    head_wnext  = NEXT_W'(ptr_idx);
    head_wvld   = 1'b1;
    start_alloc = 1'b0;

    unique case (state_q)
      psca_pkg::S_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(psca_pkg::HDR_DEPTH - 1)) state_d = psca_pkg::S_IDLE;
      end

      psca_pkg::S_IDLE: begin
        if (s_axis_tvalid) state_d = psca_pkg::S_DECODE;
      end

      psca_pkg::S_DECODE: begin
        move_d     = 1'b0;
        res_addr_d = '0;
        res_st_d   = psca_pkg::ST_OK;
        res_copy_d = '0;
        unique case (act_q)
          psca_pkg::ACT_ALLOC: start_alloc = 1'b1;
          psca_pkg::ACT_FREE,
          psca_pkg::ACT_REALLOC: begin
            if (ptr_zero) begin
              if (act_q == psca_pkg::ACT_REALLOC) start_alloc = 1'b1;
              else state_d = psca_pkg::S_DONE;
            end else if (!ptr_ok) begin
              res_st_d = psca_pkg::ST_BAD_PTR;
              state_d  = psca_pkg::S_DONE;
            end else begin
              mem_en  = 1'b1;
              state_d = psca_pkg::S_HDR;
            end
          end
          psca_pkg::ACT_NONE: state_d = psca_pkg::S_DONE;
          default: state_d = psca_pkg::S_DONE;
        endcase
      end

      psca_pkg::S_HDR: begin
        if (!(mem_rdata_q.start && mem_rdata_q.alloc)) begin
          res_st_d = psca_pkg::ST_BAD_PTR;
          state_d  = psca_pkg::S_DONE;
        end else if (act_q == psca_pkg::ACT_FREE) begin
          cls_sel = mem_rdata_q.cls;
          mem_en  = 1'b1;
          mem_we  = 1'b1;
          head_we = rel_push;
          state_d = psca_pkg::S_DONE;
        end else if (osize_ge) begin
          res_addr_d = ptr_q;
          state_d    = psca_pkg::S_DONE;
        end else begin
          hold_d      = mem_rdata_q;
          move_d      = 1'b1;
          start_alloc = 1'b1;
        end
      end

      psca_pkg::S_POP: begin
        mem_addr = IDX_W'(head_sel);
        if (!mem_rdata_q.start || mem_rdata_q.alloc || (mem_rdata_q.cls != p_cls)) begin
          res_st_d = psca_pkg::ST_CORRUPT;
          state_d  = psca_pkg::S_DONE;
        end else begin
          mem_en     = 1'b1;
          mem_we     = 1'b1;
          mem_wdata  = pop_hdr;
          head_we    = 1'b1;
          head_wnext = mem_rdata_q.next;
          head_wvld  = mem_rdata_q.next_vld;
          res_addr_d = ADDR_W'((32'(head_sel) << GRAN_SH) + psca_pkg::HEADER_BYTES);
          state_d    = move_q ? psca_pkg::S_REL : psca_pkg::S_DONE;
        end
      end

      psca_pkg::S_REL: begin
        cls_sel    = hold_q.cls;
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        head_we    = rel_push;
        res_copy_d = COPY_W'(33'(1) << hold_q.cls);
        state_d    = psca_pkg::S_DONE;
      end

      psca_pkg::S_DONE: begin
        if (out_free) state_d = psca_pkg::S_IDLE;
      end

      default: state_d = psca_pkg::S_IDLE;
    endcase

    // allocation entry: pop a class stack or bump the break pointer, else flag an error
    if (start_alloc) begin
      cls_sel = p_cls;
      if (too_large) begin
        res_st_d = psca_pkg::ST_TOO_LARGE;
        state_d  = psca_pkg::S_DONE;
      end else if (head_vld_sel) begin
        if (!head_in_range) begin
          res_st_d = psca_pkg::ST_CORRUPT;
          state_d  = psca_pkg::S_DONE;
        end else begin
          mem_en   = 1'b1;
          mem_addr = IDX_W'(head_sel);
          state_d  = psca_pkg::S_POP;
        end
      end else if (no_mem) begin
        res_st_d = psca_pkg::ST_NO_MEM;
        state_d  = psca_pkg::S_DONE;
      end else begin
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        mem_addr   = IDX_W'(bp_q >> GRAN_SH);
        mem_wdata  = bump_hdr;
        bp_d       = bp_q + bsize;
        res_addr_d = ADDR_W'(bp_q + BP_W'(psca_pkg::HEADER_BYTES));
        state_d    = move_d ? psca_pkg::S_REL : psca_pkg::S_DONE;
      end
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psca_pkg::S_CLEAR;
      clr_q       <= '0;
      bp_q        <= '0;
      limit_q     <= LIM_W'(1048576);
      move_q      <= 1'b0;
      out_valid_q <= 1'b0;
      head_q      <= '{default: '0};
      head_vld_q  <= '{default: 1'b0};
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      bp_q    <= bp_d;
      move_q  <= move_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (head_we) begin
        head_q[cls_sel]     <= head_wnext;
        head_vld_q[cls_sel] <= head_wvld;
      end
      if (state_q == psca_pkg::S_DONE && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready)                     out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act_q <= psca_pkg::action_e'(s_axis_tdata[1:0]);
      n_q   <= s_axis_tdata[25:2];
      ptr_q <= s_axis_tdata[45:26];
    end
    hold_q     <= hold_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    res_copy_q <= res_copy_d;
    if (state_q == psca_pkg::S_DONE && out_free) begin
      out_addr_q <= (res_st_q == psca_pkg::ST_OK) ? res_addr_q : '0;
      out_st_q   <= res_st_q;
      out_copy_q <= (res_st_q == psca_pkg::ST_OK) ? res_copy_q : '0;
    end
  end

  // header RAM, one access per cycle, registered read
  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      if (mem_we) hdr_mem[mem_addr] <= mem_wdata;
      else        mem_rdata_q       <= hdr_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------- checks
  a_bp_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> bp_q >= $past(bp_q))
    else $error("break pointer moved backwards");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_st_q != psca_pkg::ST_OK) |-> (out_addr_q == '0 && out_copy_q == '0))
    else $error("failed transaction carries an address or copy count");

  a_read_before_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psca_pkg::S_HDR || state_q == psca_pkg::S_POP) |-> $past(mem_en && !mem_we))
    else $error("header consumed without a preceding RAM read");

endmodule
